>>> hdl/pec_pkg.sv
// shared constants, codes and a fixed-point helper for the polynomial easing curve
package pec_pkg;

    // fixed-point format of normalized time and curve values
    localparam int FRAC_BITS = 16;
    localparam int Q_BITS    = FRAC_BITS + 1;
    localparam logic [Q_BITS-1:0] ONE_Q  = Q_BITS'(1) << FRAC_BITS;
    localparam logic [Q_BITS-1:0] HALF_Q = Q_BITS'(1) << (FRAC_BITS - 1);

    // default field widths
    localparam int TIME_BITS_DEFAULT  = 16;
    localparam int VALUE_BITS_DEFAULT = 24;

    // pipeline depth: input, one stage per quotient bit, base, powers, post, product, sum
    localparam int MUL_STAGES = 4;
    localparam int NUM_STAGES = 1 + Q_BITS + 1 + MUL_STAGES + 3;

    // curve degree codes
    localparam logic [2:0] KIND_LINEAR    = 3'd0;
    localparam logic [2:0] KIND_QUADRATIC = 3'd1;
    localparam logic [2:0] KIND_CUBIC     = 3'd2;
    localparam logic [2:0] KIND_QUARTIC   = 3'd3;
    localparam logic [2:0] KIND_QUINTIC   = 3'd4;

    // direction codes
    localparam logic [1:0] DIR_IN    = 2'd0;
    localparam logic [1:0] DIR_OUT   = 2'd1;
    localparam logic [1:0] DIR_INOUT = 2'd2;

    // rounded Q1.16 product of two values in [0, 1.0]
    function automatic logic [Q_BITS-1:0] qmul(input logic [Q_BITS-1:0] a,
                                               input logic [Q_BITS-1:0] y);
        logic [2*Q_BITS-1:0] pr;
        pr = (2*Q_BITS)'(a) * (2*Q_BITS)'(y) + (2*Q_BITS)'(HALF_Q);
        return pr[FRAC_BITS+Q_BITS-1:FRAC_BITS];
    endfunction

endpackage

>>> hdl/polynomial_easing_curve.sv
// top level: pipelined polynomial easing curve evaluator
//
// One request on the s_ channel gives one result on the m_ channel.
// s_tuser carries kind (bits 2:0) and direction (bits 4:3); s_tdata carries
// elapsed, duration, start_value and change. m_tdata carries the signed value.
// Normalized time t/d is formed by a restoring divider with one quotient bit
// per stage (17 stages), then the curve power is built by four rounded Q1.16
// multiply stages, and c * e(u) is formed by one signed multiply stage.
// A result leaves after its request has passed every stage register in order.
// Throughput: one request per cycle when not stalled; every stage holds one request.
// Each stage moves on when its successor is empty or moving, so a stalled
// receiver freezes only the full tail of the pipeline and bubbles ahead of
// it still fill; s_tready drops once the input stage is full and cannot move on.
// Results leave in request order and a stall loses or repeats nothing.
// Reset (aresetn low, synchronous) empties every stage; data registers are
// left as they are.
module polynomial_easing_curve #(
    parameter int TIME_BITS  = pec_pkg::TIME_BITS_DEFAULT,
    parameter int VALUE_BITS = pec_pkg::VALUE_BITS_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    // s_tdata: elapsed, duration, start_value, change (lowest bits first), zero padded
    input  logic [((2*TIME_BITS+2*VALUE_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: kind [2:0], direction [4:3]
    input  logic [4:0] s_tuser,
    input  logic s_tvalid,
    output logic s_tready,
    // m_tdata: value, zero padded
    output logic [((VALUE_BITS+1+7)/8)*8-1:0] m_tdata,
    output logic m_tvalid,
    input  logic m_tready
);
    import pec_pkg::*;

    localparam int TB       = TIME_BITS;
    localparam int VB       = VALUE_BITS;
    localparam int PW       = VB + Q_BITS + 1;
    localparam int M_DATA_W = ((VB + 1 + 7) / 8) * 8;
    localparam int IDX_BASE = 1 + Q_BITS;
    localparam int IDX_POST = IDX_BASE + MUL_STAGES + 1;
    localparam int IDX_PROD = IDX_POST + 1;
    localparam int IDX_SUM  = IDX_PROD + 1;

    typedef struct packed {
        logic [2:0]             kind;
        logic [1:0]             dir;
        logic                   dzero;
        logic                   upper;
        logic [TB-1:0]          den;
        logic [TB:0]            rem;
        logic [Q_BITS-1:0]      quo;
        logic [Q_BITS-1:0]      xb;
        logic [Q_BITS-1:0]      pw;
        logic signed [VB-1:0]   b;
        logic signed [VB-1:0]   c;
        logic signed [PW-1:0]   prod;
        logic signed [VB:0]     val;
    } stage_t;

    stage_t stg_reg [NUM_STAGES];
    logic   vld_reg [NUM_STAGES];
    logic   en      [NUM_STAGES];

    // stage enables: a stage loads when it is empty or its successor loads
    always_comb begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = M_DATA_W'($unsigned(stg_reg[NUM_STAGES-1].val));

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        stage_t stg_next;

        if (k == 0) begin : g_in
            // input capture: clamp elapsed to duration, normalize codes
            always_comb begin
                logic [TB-1:0] t_in;
                logic [TB-1:0] d_in;
                logic [2:0]    kind_in;
                logic [1:0]    dir_in;
                t_in    = s_tdata[TB-1:0];
                d_in    = s_tdata[2*TB-1:TB];
                kind_in = s_tuser[2:0];
                dir_in  = s_tuser[4:3];
                stg_next       = stg_reg[0];
                stg_next.kind  = (kind_in > KIND_QUINTIC) ? KIND_LINEAR : kind_in;
                stg_next.dir   = (dir_in == DIR_OUT || dir_in == DIR_INOUT) ? dir_in : DIR_IN;
                stg_next.dzero = (d_in == '0);
                stg_next.den   = d_in;
                stg_next.rem   = {1'b0, (t_in > d_in) ? d_in : t_in};
                stg_next.quo   = '0;
                stg_next.b     = s_tdata[2*TB+VB-1:2*TB];
                stg_next.c     = s_tdata[2*TB+2*VB-1:2*TB+VB];
            end
        end else if (k < IDX_BASE) begin : g_div
            // restoring division: one quotient bit, most significant first
            always_comb begin
                logic [TB:0] trial;
                trial = (k == 1) ? stg_reg[k-1].rem : {stg_reg[k-1].rem[TB-1:0], 1'b0};
                stg_next = stg_reg[k-1];
                if (trial >= {1'b0, stg_reg[k-1].den}) begin
                    stg_next.quo[Q_BITS-k] = 1'b1;
                    stg_next.rem           = trial - {1'b0, stg_reg[k-1].den};
                end else begin
                    stg_next.rem = trial;
                end
            end
        end else if (k == IDX_BASE) begin : g_base
            // curve argument for the chosen direction
            always_comb begin
                logic [Q_BITS-1:0] u;
                logic [1:0]        dir_eff;
                u       = stg_reg[k-1].dzero ? ONE_Q : stg_reg[k-1].quo;
                dir_eff = (stg_reg[k-1].kind == KIND_LINEAR) ? DIR_IN : stg_reg[k-1].dir;
                stg_next       = stg_reg[k-1];
                stg_next.dir   = dir_eff;
                stg_next.upper = (u >= HALF_Q);
                unique case (dir_eff)
                    DIR_IN:    stg_next.xb = u;
                    DIR_OUT:   stg_next.xb = ONE_Q - u;
                    DIR_INOUT: stg_next.xb = (u >= HALF_Q) ? ((ONE_Q - u) << 1) : (u << 1);
                    default:   stg_next.xb = u;
                endcase
                stg_next.pw = stg_next.xb;
            end
        end else if (k < IDX_POST) begin : g_mul
            // one more power of the argument when the degree calls for it
            always_comb begin
                stg_next = stg_reg[k-1];
                if (stg_reg[k-1].kind >= 3'(k - IDX_BASE)) begin
                    stg_next.pw = qmul(stg_reg[k-1].pw, stg_reg[k-1].xb);
                end
            end
        end else if (k == IDX_POST) begin : g_post
            // fold the power back into the curve value
            always_comb begin
                logic [Q_BITS:0] half_p;
                half_p   = ({1'b0, stg_reg[k-1].pw} + (Q_BITS+1)'(1)) >> 1;
                stg_next = stg_reg[k-1];
                unique case (stg_reg[k-1].dir)
                    DIR_IN:    stg_next.pw = stg_reg[k-1].pw;
                    DIR_OUT:   stg_next.pw = ONE_Q - stg_reg[k-1].pw;
                    DIR_INOUT: stg_next.pw = stg_reg[k-1].upper
                                             ? ONE_Q - half_p[Q_BITS-1:0]
                                             : half_p[Q_BITS-1:0];
                    default:   stg_next.pw = stg_reg[k-1].pw;
                endcase
            end
        end else if (k == IDX_PROD) begin : g_prod
            // scaled change with the rounding half added
            always_comb begin
                stg_next      = stg_reg[k-1];
                stg_next.prod = PW'(stg_reg[k-1].c) * $signed({1'b0, stg_reg[k-1].pw})
                              + PW'($signed({1'b0, HALF_Q}));
            end
        end else begin : g_sum
            // floor shift and start value
            always_comb begin
                logic signed [VB+1:0] q;
                logic signed [VB+1:0] sum;
                q        = stg_reg[k-1].prod[PW-1:FRAC_BITS];
                sum      = q + (VB+2)'(stg_reg[k-1].b);
                stg_next = stg_reg[k-1];
                stg_next.val = sum[VB:0];
            end
        end

        // stage registers
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en[k]) begin
                vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k-1];
            end
            if (en[k]) begin
                stg_reg[k] <= stg_next;
            end
        end
    end

endmodule

>>> hdl/pec_checker.sv
// port-level checker for the polynomial easing curve, bound to the top level
module pec_checker #(
    parameter int TIME_BITS  = pec_pkg::TIME_BITS_DEFAULT,
    parameter int VALUE_BITS = pec_pkg::VALUE_BITS_DEFAULT
) (
    input logic aclk,
    input logic aresetn,
    input logic [((2*TIME_BITS+2*VALUE_BITS+7)/8)*8-1:0] s_tdata,
    input logic [4:0] s_tuser,
    input logic s_tvalid,
    input logic s_tready,
    input logic [((VALUE_BITS+1+7)/8)*8-1:0] m_tdata,
    input logic m_tvalid,
    input logic m_tready
);
    import pec_pkg::*;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // a receiver that takes results never blocks new requests
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while output is drained");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

endmodule

bind polynomial_easing_curve pec_checker #(
    .TIME_BITS (TIME_BITS),
    .VALUE_BITS(VALUE_BITS)
) u_pec_checker (.*);

>>> verif/easing_result_checker.sv
// result checker for the polynomial easing curve: predicts every value and compares it
module easing_result_checker #(
    parameter int TIME_BITS  = pec_pkg::TIME_BITS_DEFAULT,
    parameter int VALUE_BITS = pec_pkg::VALUE_BITS_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    // s_tdata: elapsed, duration, start_value, change (lowest bits first), zero padded
    input  logic [((2*TIME_BITS+2*VALUE_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: kind [2:0], direction [4:3]
    input  logic [4:0] s_tuser,
    input  logic s_tvalid,
    input  logic s_tready,
    // m_tdata: value, zero padded
    input  logic [((VALUE_BITS+1+7)/8)*8-1:0] m_tdata,
    input  logic m_tvalid,
    input  logic m_tready,
    output int   mismatches,
    output int   outstanding,
    output int   results_checked
);
    import pec_pkg::*;

    // one request as seen on the input side, with its predicted value
    typedef struct {
        logic [2:0]                  kind;
        logic [1:0]                  dir;
        logic [TIME_BITS-1:0]        elapsed;
        logic [TIME_BITS-1:0]        duration;
        logic signed [VALUE_BITS-1:0] start_value;
        logic signed [VALUE_BITS-1:0] change;
        logic signed [VALUE_BITS:0]   value;
    } eased_request_t;

    eased_request_t pending_values[$];
    int fail_total = 0;
    int checked_total = 0;

    assign mismatches      = fail_total;
    assign results_checked = checked_total;

    // rounded Q1.16 product, operands in [0, 1.0]
    function automatic logic [Q_BITS-1:0] fixed_product(input logic [Q_BITS-1:0] x,
                                                        input logic [Q_BITS-1:0] y);
        return Q_BITS'((64'(x) * 64'(y) + 64'(HALF_Q)) >> FRAC_BITS);
    endfunction

    // x raised to degree, multiplied in left to right
    function automatic logic [Q_BITS-1:0] fixed_power(input logic [Q_BITS-1:0] x,
                                                      input int degree);
        logic [Q_BITS-1:0] p;
        p = x;
        for (int i = 1; i < degree; i++) begin
            p = fixed_product(p, x);
        end
        return p;
    endfunction

    // easing fraction e(u) for one degree and direction
    function automatic logic [Q_BITS-1:0] curve_fraction(input logic [Q_BITS-1:0] u,
                                                         input int degree,
                                                         input logic [1:0] dir);
        logic [Q_BITS-1:0] w;
        logic [Q_BITS:0]   half_up;
        if (degree == 1) begin
            return u;
        end
        if (dir == DIR_OUT) begin
            return ONE_Q - fixed_power(ONE_Q - u, degree);
        end
        if (dir == DIR_INOUT) begin
            // first half rises as ease in, second half mirrors it
            if (u < HALF_Q) begin
                w = u << 1;
                half_up = ((Q_BITS+1)'(fixed_power(w, degree)) + 1'b1) >> 1;
                return Q_BITS'(half_up);
            end
            w = (ONE_Q - u) << 1;
            half_up = ((Q_BITS+1)'(fixed_power(w, degree)) + 1'b1) >> 1;
            return ONE_Q - Q_BITS'(half_up);
        end
        return fixed_power(u, degree);
    endfunction

    // b + c * e(t/d), rounded with halves going up
    function automatic logic signed [VALUE_BITS:0] eased_value(
        input logic [2:0]                  kind,
        input logic [1:0]                  dir,
        input logic [TIME_BITS-1:0]        elapsed,
        input logic [TIME_BITS-1:0]        duration,
        input logic signed [VALUE_BITS-1:0] start_value,
        input logic signed [VALUE_BITS-1:0] change
    );
        logic [TIME_BITS-1:0] t_clamped;
        logic [Q_BITS-1:0]    u;
        logic [Q_BITS-1:0]    e;
        logic [1:0]           shape;
        int                   degree;
        longint               base;
        longint               scaled;
        base = longint'(start_value);
        // zero duration jumps straight to the end value
        if (duration == '0) begin
            return (VALUE_BITS+1)'(base + longint'(change));
        end
        t_clamped = (elapsed > duration) ? duration : elapsed;
        u = Q_BITS'({t_clamped, {FRAC_BITS{1'b0}}} / duration);
        // unused kind codes fall back to linear, unused direction to ease in
        degree = (kind <= KIND_QUINTIC) ? int'(kind) + 1 : 1;
        shape = (dir > DIR_INOUT) ? DIR_IN : dir;
        e = curve_fraction(u, degree, shape);
        scaled = longint'(change) * longint'(e) + longint'(HALF_Q);
        return (VALUE_BITS+1)'(base + (scaled >>> FRAC_BITS));
    endfunction

    // compare each result with the oldest prediction, then record new requests
    always @(posedge aclk) begin : track_requests
        eased_request_t due;
        eased_request_t req;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_values.size() == 0) begin
                    $display("%0t: result with no request waiting: expected none, actual %0d",
                             $time, $signed(m_tdata[VALUE_BITS:0]));
                    fail_total++;
                end else begin
                    due = pending_values.pop_front();
                    checked_total++;
                    if (m_tdata[VALUE_BITS:0] !== due.value) begin
                        $display(
                            "%0t: expected %0d actual %0d, kind %0d dir %0d t %0d d %0d b %0d c %0d",
                            $time, due.value, $signed(m_tdata[VALUE_BITS:0]),
                            due.kind, due.dir, due.elapsed, due.duration,
                            due.start_value, due.change);
                        fail_total++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                req.kind        = s_tuser[2:0];
                req.dir         = s_tuser[4:3];
                req.elapsed     = s_tdata[TIME_BITS-1:0];
                req.duration    = s_tdata[2*TIME_BITS-1:TIME_BITS];
                req.start_value = s_tdata[2*TIME_BITS+VALUE_BITS-1:2*TIME_BITS];
                req.change      = s_tdata[2*TIME_BITS+2*VALUE_BITS-1:2*TIME_BITS+VALUE_BITS];
                req.value       = eased_value(req.kind, req.dir, req.elapsed, req.duration,
                                              req.start_value, req.change);
                pending_values.push_back(req);
            end
        end
        outstanding <= pending_values.size();
    end

endmodule

>>> verif/testbench.sv
// testbench top: clock, reset, request stimulus, result backpressure and verdict
module testbench;
    import pec_pkg::*;

    localparam int TIME_BITS  = TIME_BITS_DEFAULT;
    localparam int VALUE_BITS = VALUE_BITS_DEFAULT;
    localparam int SDATA_BITS = ((2*TIME_BITS+2*VALUE_BITS+7)/8)*8;
    localparam int MDATA_BITS = ((VALUE_BITS+1+7)/8)*8;

    localparam logic [1:0] DIR_UNUSED        = 2'd3;
    localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = NUM_STAGES + 8;
    localparam int WATCHDOG_LIMIT  = 4 * (HOLD_OFF_CYCLES + NUM_STAGES + 32);

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [SDATA_BITS-1:0] s_tdata  = '0;
    logic [4:0]            s_tuser  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [MDATA_BITS-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;

    int mismatches;
    int outstanding;
    int results_checked;

    bit calm = 1'b0;
    bit hold_off_pending = 1'b0;
    int sent_count = 0;
    int zero_duration_count = 0;
    int clamped_count = 0;
    int idle_cycles = 0;

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    polynomial_easing_curve #(
        .TIME_BITS (TIME_BITS),
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    easing_result_checker #(
        .TIME_BITS (TIME_BITS),
        .VALUE_BITS(VALUE_BITS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .results_checked(results_checked)
    );

    // result side backpressure, with one long hold-off when asked
    initial begin : result_receiver
        forever begin
            @(posedge aclk);
            if (hold_off_pending) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_pending = 1'b0;
            end
            m_tready <= calm || ($urandom_range(99) >= 11);
        end
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one request, with an occasional gap before it, and wait for acceptance
    task automatic send_request(input logic [2:0] kind, input logic [1:0] dir,
                                input logic [TIME_BITS-1:0] elapsed, duration,
                                input logic [VALUE_BITS-1:0] start_value, change);
        if (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tdata  <= SDATA_BITS'({change, start_value, duration, elapsed});
        s_tuser  <= {dir, kind};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
        if (duration == '0) begin
            zero_duration_count++;
        end else if (elapsed > duration) begin
            clamped_count++;
        end
    endtask

    // stop offering until every predicted value has come back
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // signed value, biased toward the extremes and zero
    function automatic logic [VALUE_BITS-1:0] random_value();
        case ($urandom_range(9))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2: return '0;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    // random request: mostly legal codes, many short durations, some clamped times
    task automatic send_random_request();
        logic [2:0]            kind;
        logic [1:0]            dir;
        logic [TIME_BITS-1:0]  elapsed;
        logic [TIME_BITS-1:0]  duration;
        int                    pick;
        if ($urandom_range(99) < 6) begin
            kind = 3'($urandom_range(KIND_UNUSED_LAST, KIND_QUINTIC + 1));
        end else begin
            kind = 3'($urandom_range(KIND_QUINTIC, KIND_LINEAR));
        end
        dir = ($urandom_range(99) < 5) ? DIR_UNUSED : 2'($urandom_range(DIR_INOUT, DIR_IN));
        pick = $urandom_range(99);
        if (pick < 8) begin
            duration = '0;
        end else if (pick < 40) begin
            duration = TIME_BITS'($urandom_range(16, 1));
        end else begin
            duration = TIME_BITS'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 12) begin
            elapsed = TIME_BITS'($urandom_range(TIME_MAX, duration));
        end else if (pick < 20) begin
            elapsed = duration;
        end else if (pick < 25) begin
            elapsed = '0;
        end else begin
            elapsed = TIME_BITS'($urandom_range(duration, 0));
        end
        send_request(kind, dir, elapsed, duration, random_value(), random_value());
    endtask

    // reset, directed requests, random phases, drain and verdict
    initial begin : stimulus
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes, zero duration, elapsed past duration, in-out around the midpoint
        send_request(KIND_QUINTIC, DIR_IN, '0, TIME_MAX, VALUE_MAX, VALUE_MAX);
        send_request(KIND_QUINTIC, DIR_OUT, TIME_MAX, TIME_MAX, VALUE_MIN, VALUE_MIN);
        send_request(KIND_LINEAR, DIR_IN, TIME_MAX, '0, VALUE_MAX, VALUE_MAX);
        send_request(KIND_CUBIC, DIR_OUT, '0, '0, VALUE_MIN, VALUE_MAX);
        send_request(KIND_CUBIC, DIR_INOUT, TIME_MAX, TIME_BITS'(1), VALUE_MAX, VALUE_MIN);
        send_request(KIND_QUARTIC, DIR_INOUT, TIME_BITS'(1), TIME_BITS'(2), '0, VALUE_MAX);
        send_request(KIND_QUADRATIC, DIR_INOUT, TIME_BITS'(32767), TIME_MAX, '0, VALUE_MIN);

        // every degree in every direction
        for (int k = KIND_LINEAR; k <= KIND_QUINTIC; k++) begin
            for (int r = DIR_IN; r <= DIR_INOUT; r++) begin
                send_request(3'(k), 2'(r), TIME_BITS'($urandom),
                             TIME_BITS'($urandom_range(TIME_MAX, 1)),
                             random_value(), random_value());
            end
        end

        // unused kind codes and the unused direction code
        for (int k = KIND_QUINTIC + 1; k <= KIND_UNUSED_LAST; k++) begin
            send_request(3'(k), 2'($urandom_range(DIR_UNUSED, DIR_IN)),
                         TIME_BITS'($urandom_range(TIME_MAX / 2)), TIME_MAX / 2,
                         random_value(), random_value());
        end
        send_request(KIND_CUBIC, DIR_UNUSED, TIME_BITS'(3), TIME_BITS'(7),
                     VALUE_MIN, VALUE_MAX);

        // random requests with idling on both sides
        repeat (600) send_random_request();

        // long stretch with no idling
        calm = 1'b1;
        repeat (300) send_random_request();
        calm = 1'b0;

        // receiver holds off while requests keep coming, so the pipeline fills
        hold_off_pending = 1'b1;
        repeat (150) send_random_request();

        // pause until every result is back, then more random traffic
        wait_until_drained();
        repeat (776) send_random_request();

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("summary: %0d requests sent, %0d results checked, every kind and direction code",
                 sent_count, results_checked);
        $display("summary: %0d zero-duration, %0d past-duration, one %0d-cycle receiver hold-off",
                 zero_duration_count, clamped_count, HOLD_OFF_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (outstanding != 0) begin
                $display("%0t: %0d predicted results never arrived", $time, outstanding);
            end
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/pec_pkg.sv
hdl/polynomial_easing_curve.sv
hdl/pec_checker.sv
verif/easing_result_checker.sv
verif/testbench.sv
